### rtl/hcbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hcbd_pkg;

	// width of the chunk size accumulator and of the per-chunk down counter
	localparam int unsigned SIZE_BITS = 32;
	// fixed widths of the counters and of the limit register
	localparam int unsigned LEN_BITS  = 32;
	// depth of the result queue between parser and output stage
	localparam int unsigned Q_DEPTH   = 2;
	localparam int unsigned Q_PTR_W   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int unsigned Q_CNT_W   = $clog2(Q_DEPTH + 1);

	localparam logic [LEN_BITS-1:0] MAX_LEN_RESET = '1;

	// ascii codes the size line parser looks at
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_LEAD  = 3'd1,
		PH_DIGIT = 3'd2,
		PH_REST  = 3'd3,
		PH_CR    = 3'd4,
		PH_DATA  = 3'd5,
		PH_TRAIL = 3'd6,
		PH_HALT  = 3'd7
	} phase_t;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_END  = 2'd1,
		KIND_SIZE = 2'd2,
		KIND_LONG = 2'd3
	} kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_body;
	} in_req_t;

	typedef struct packed {
		logic [7:0]          out_byte;
		logic [1:0]          out_kind;
		logic [LEN_BITS-1:0] body_length;
	} out_req_t;

	// hex digit decode: valid flag in bit 4, value in bits 3:0
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/hcbd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module hcbd_front import hcbd_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [LEN_BITS-1:0] cfg_wdata,
	input  wire logic                acc_en,
	input  wire in_req_t             req,
	output logic                     res_valid,
	output out_req_t                 res
);

	logic [LEN_BITS-1:0]  max_len_q;
	phase_t               phase_q, ph_e, phase_d;
	logic [SIZE_BITS-1:0] size_q, size_e, size_d;
	logic [SIZE_BITS-1:0] left_q, left_e, left_d;
	logic [LEN_BITS-1:0]  pay_q, pay_e, pay_d;
	logic [LEN_BITS-1:0]  raw_q, raw_e, raw_d;
	logic                 neg_q, neg_e, neg_d;

	logic [7:0] c;
	logic [4:0] hx;
	logic       is_ws, is_cr, is_lf, is_sign, active, over, size_ovf, left_one;
	kind_t      kind;

	// start of body clears the parser before the byte is looked at
	always_comb begin
		c       = req.data_byte;
		hx      = hex_decode(c);
		is_ws   = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF)
		          || (c == CH_VT) || (c == CH_FF);
		is_cr   = (c == CH_CR);
		is_lf   = (c == CH_LF);
		is_sign = (c == CH_PLUS) || (c == CH_MINUS);
		if (req.start_of_body) begin
			ph_e   = PH_LEAD;
			size_e = '0;
			left_e = '0;
			pay_e  = '0;
			raw_e  = '0;
			neg_e  = 1'b0;
		end else begin
			ph_e   = phase_q;
			size_e = size_q;
			left_e = left_q;
			pay_e  = pay_q;
			raw_e  = raw_q;
			neg_e  = neg_q;
		end
		active   = (ph_e != PH_IDLE) && (ph_e != PH_HALT);
		over     = (raw_e >= max_len_q);
		size_ovf = (size_e[SIZE_BITS-1 -: 4] != 4'd0);
		left_one = (left_e == SIZE_BITS'(1));
	end

	// next state
	always_comb begin
		phase_d = ph_e;
		if (active) begin
			if (over) begin
				phase_d = PH_HALT;
			end else begin
				unique case (ph_e)
					PH_LEAD: begin
						priority if (is_ws) phase_d = PH_LEAD;
						else if (is_cr)     phase_d = PH_CR;
						else if (is_sign)   phase_d = PH_DIGIT;
						else if (!hx[4])    phase_d = PH_REST;
						else                phase_d = PH_DIGIT;
					end
					PH_DIGIT: begin
						priority if (hx[4]) phase_d = size_ovf ? PH_HALT : PH_DIGIT;
						else if (is_cr)     phase_d = PH_CR;
						else                phase_d = PH_REST;
					end
					PH_REST: begin
						if (is_cr) phase_d = PH_CR;
					end
					PH_CR: begin
						priority if (is_cr)        phase_d = PH_CR;
						else if (!is_lf)           phase_d = PH_REST;
						else if (size_e == '0)     phase_d = PH_HALT;
						else if (neg_e)            phase_d = PH_HALT;
						else                       phase_d = PH_DATA;
					end
					PH_DATA: begin
						if (left_one) phase_d = PH_TRAIL;
					end
					PH_TRAIL: begin
						if (left_one) phase_d = PH_LEAD;
					end
					default: phase_d = ph_e;
				endcase
			end
		end
	end

	// outputs and datapath
	always_comb begin
		size_d    = size_e;
		left_d    = left_e;
		pay_d     = pay_e;
		raw_d     = raw_e;
		neg_d     = neg_e;
		res_valid = 1'b0;
		kind      = KIND_DATA;
		res       = '0;
		if (active) begin
			if (over) begin
				res_valid = 1'b1;
				kind      = KIND_LONG;
			end else begin
				raw_d = raw_e + LEN_BITS'(1);
				unique case (ph_e)
					PH_LEAD: begin
						if (!is_ws && !is_cr) begin
							if (is_sign) begin
								neg_d = (c == CH_MINUS);
							end else if (hx[4]) begin
								size_d = {size_e[SIZE_BITS-5:0], hx[3:0]};
							end
						end
					end
					PH_DIGIT: begin
						if (hx[4]) begin
							if (size_ovf) begin
								res_valid = 1'b1;
								kind      = KIND_SIZE;
							end else begin
								size_d = {size_e[SIZE_BITS-5:0], hx[3:0]};
							end
						end
					end
					PH_CR: begin
						if (is_lf) begin
							if (size_e == '0) begin
								res_valid = 1'b1;
								kind      = KIND_END;
							end else if (neg_e) begin
								res_valid = 1'b1;
								kind      = KIND_SIZE;
							end else begin
								left_d = size_e;
							end
						end
					end
					PH_DATA: begin
						pay_d     = pay_e + LEN_BITS'(1);
						left_d    = left_one ? SIZE_BITS'(2) : left_e - SIZE_BITS'(1);
						res_valid = 1'b1;
						kind      = KIND_DATA;
					end
					PH_TRAIL: begin
						left_d = left_e - SIZE_BITS'(1);
						if (left_one) begin
							size_d = '0;
							neg_d  = 1'b0;
						end
					end
					default: ;
				endcase
			end
		end
		res.out_kind    = kind;
		res.out_byte    = (kind == KIND_DATA) ? c : 8'd0;
		res.body_length = pay_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_we) begin
			max_len_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			size_q  <= '0;
			left_q  <= '0;
			pay_q   <= '0;
			raw_q   <= '0;
			neg_q   <= 1'b0;
		end else if (acc_en) begin
			phase_q <= phase_d;
			size_q  <= size_d;
			left_q  <= left_d;
			pay_q   <= pay_d;
			raw_q   <= raw_d;
			neg_q   <= neg_d;
		end
	end

endmodule

`default_nettype wire

### rtl/hcbd_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module hcbd_queue import hcbd_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire out_req_t push_data,
	input  wire logic     pop,
	output logic          full,
	output logic          not_empty,
	output out_req_t      head
);

	out_req_t             slot_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [Q_CNT_W-1:0]   count_q;

	assign full      = (count_q == Q_CNT_W'(Q_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_ptr_q];

	function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
		return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + Q_PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
			unique case ({push, pop})
				2'b10:   count_q <= count_q + Q_CNT_W'(1);
				2'b01:   count_q <= count_q - Q_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/hcbd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module hcbd_back import hcbd_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     q_not_empty,
	input  wire out_req_t q_head,
	output logic          q_pop,
	output logic          dst_valid,
	input  wire logic     dst_ready,
	output out_req_t      dst_data
);

	logic     valid_q;
	out_req_t data_q;

	// refill the output register whenever it is empty or being taken
	assign q_pop     = q_not_empty && (!valid_q || dst_ready);
	assign dst_valid = valid_q;
	assign dst_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || dst_ready) begin
			valid_q <= q_not_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			data_q <= q_head;
		end
	end

endmodule

`default_nettype wire

### rtl/http_chunked_body_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   | direction | handshake                | payload
// ----------+-----------+--------------------------+---------------------------------
// src       | in        | src_valid / src_ready    | in_req_t  (data_byte, start_of_body)
// dst       | out       | dst_valid / dst_ready    | out_req_t (out_byte, out_kind, body_length)
// cfg       | in        | cfg_we, no back-pressure | max_body_length
//
// one raw byte is taken per clock while src_ready is high; each byte is parsed in the cycle it arrives
// at most one request per byte goes into a two-entry queue, then to the output register
// src_ready drops only while the queue holds two requests that have not moved on
// a result passes a queue slot and the output register; reset leaves the parser idle and the
// limit at all ones, and bytes without a start flag are dropped until a body begins

module http_chunked_body_decoder import hcbd_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [LEN_BITS-1:0] cfg_wdata,
	input  wire logic                src_valid,
	output logic                     src_ready,
	input  wire in_req_t             src_data,
	output logic                     dst_valid,
	input  wire logic                dst_ready,
	output out_req_t                 dst_data
);

	logic     accept;
	logic     res_valid;
	out_req_t res;
	logic     q_full, q_not_empty, q_pop;
	out_req_t q_head;

	// front: size line parser and chunk byte counting, one byte per accepted request
	assign src_ready = !q_full;
	assign accept    = src_valid && src_ready;

	hcbd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.acc_en    (accept),
		.req       (src_data),
		.res_valid (res_valid),
		.res       (res)
	);

	// short queue decouples parsing from output stalls
	hcbd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && res_valid),
		.push_data (res),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	// back: output register towards the consumer
	hcbd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.dst_valid   (dst_valid),
		.dst_ready   (dst_ready),
		.dst_data    (dst_data)
	);

endmodule

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import hcbd_pkg::*;

	localparam int CLK_HALF      = 10;
	localparam int RESET_CYCLES  = 12;
	// a result passes the queue and the output register; leave some margin on top
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 600000;

	// clock, reset and block ports
	logic                clk         = 1'b0;
	logic                arst_n      = 1'b0;
	logic                cfg_we      = 1'b0;
	logic [LEN_BITS-1:0] cfg_wdata   = '0;
	logic                src_valid   = 1'b0;
	logic                src_ready;
	in_req_t             src_data    = '0;
	logic                dst_valid;
	logic                dst_ready   = 1'b0;
	out_req_t            dst_data;

	// idling switches, changed only between settings and away from the rising edge
	bit src_idle_en  = 1'b1;
	bit sink_idle_en = 1'b1;
	int sink_hold    = 0;

	// shadow of the decoder: own copy of the limit register and parser state
	logic [LEN_BITS-1:0]  body_limit  = MAX_LEN_RESET;
	phase_t               parse_ph    = PH_IDLE;
	logic [SIZE_BITS-1:0] size_acc    = '0;
	logic [SIZE_BITS-1:0] chunk_left  = '0;
	logic [LEN_BITS-1:0]  payload_len = '0;
	logic [LEN_BITS-1:0]  raw_len     = '0;
	bit                   size_neg    = 1'b0;

	// decoded requests still owed by the block, oldest first
	out_req_t pending_results [$];
	out_req_t want_res;

	// bytes of the body being sent
	in_req_t body_q [$];

	int unsigned cycle_cnt     = 0;
	int unsigned fail_cnt      = 0;
	int unsigned sent_bytes    = 0;
	int unsigned parsed_items  = 0;
	int unsigned bodies_sent   = 0;
	int unsigned limits_used   = 0;
	int unsigned kind_seen [4] = '{0, 0, 0, 0};

	// directed rows: the expected request is typed in where it is obvious,
	// otherwise it comes from the shadow decoder
	typedef struct {
		logic [7:0] b;
		logic       s;
		bit         typed;
		out_req_t   want;
	} step_row_t;

	step_row_t directed_rows [28] = '{
		// byte before any start is dropped
		'{8'hFF, 1'b0, 1'b0, '0},
		// leading white space, then minus zero ends the body at length zero
		'{" ",   1'b1, 1'b0, '0},
		'{8'h0B, 1'b0, 1'b0, '0},
		'{"-",   1'b0, 1'b0, '0},
		'{"0",   1'b0, 1'b0, '0},
		'{8'h0D, 1'b0, 1'b0, '0},
		'{8'h0A, 1'b0, 1'b1, '{8'h00, KIND_END, 32'd0}},
		// chunk of two with an extension, payload at both byte extremes
		'{"2",   1'b1, 1'b0, '0},
		'{";",   1'b0, 1'b0, '0},
		'{8'h0D, 1'b0, 1'b0, '0},
		'{8'h0A, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b1, '{8'hFF, KIND_DATA, 32'd1}},
		'{8'h00, 1'b0, 1'b1, '{8'h00, KIND_DATA, 32'd2}},
		'{8'h0D, 1'b0, 1'b0, '0},
		'{8'h0A, 1'b0, 1'b0, '0},
		// negative nonzero size is a sign error at the end of the line
		'{"-",   1'b0, 1'b0, '0},
		'{"A",   1'b0, 1'b0, '0},
		'{8'h0D, 1'b0, 1'b0, '0},
		'{8'h0A, 1'b0, 1'b1, '{8'h00, KIND_SIZE, 32'd2}},
		// eight digits fill the size, the ninth overflows it
		'{"f",   1'b1, 1'b0, '0},
		'{"F",   1'b0, 1'b0, '0},
		'{"f",   1'b0, 1'b0, '0},
		'{"F",   1'b0, 1'b0, '0},
		'{"f",   1'b0, 1'b0, '0},
		'{"F",   1'b0, 1'b0, '0},
		'{"f",   1'b0, 1'b0, '0},
		'{"F",   1'b0, 1'b0, '0},
		'{"a",   1'b0, 1'b1, '{8'h00, KIND_SIZE, 32'd0}}
	};

	http_chunked_body_decoder DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_data  (src_data),
		.dst_valid (dst_valid),
		.dst_ready (dst_ready),
		.dst_data  (dst_data)
	);

	always #CLK_HALF clk = ~clk;

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// receiver back-pressure: random stall bursts of random length
	always @(posedge clk) begin
		if (sink_hold != 0) begin
			dst_ready <= 1'b0;
			sink_hold <= sink_hold - 1;
		end else if (sink_idle_en && $urandom_range(0, 11) == 0) begin
			dst_ready <= 1'b0;
			sink_hold <= $urandom_range(0, 17);
		end else begin
			dst_ready <= 1'b1;
		end
	end

	// outputs are stable at the falling edge, so a request seen here is
	// the one taken at the next rising edge
	always @(negedge clk) begin
		if (arst_n && dst_valid && dst_ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected request: out_byte %0h out_kind %0d body_length %0d",
					dst_data.out_byte, dst_data.out_kind, dst_data.body_length);
				fail_cnt++;
			end else begin
				want_res = pending_results.pop_front();
				if (dst_data.out_byte !== want_res.out_byte) begin
					$error("out_byte expected %0h actual %0h",
						want_res.out_byte, dst_data.out_byte);
					fail_cnt++;
				end
				if (dst_data.out_kind !== want_res.out_kind) begin
					$error("out_kind expected %0d actual %0d",
						want_res.out_kind, dst_data.out_kind);
					fail_cnt++;
				end
				if (dst_data.body_length !== want_res.body_length) begin
					$error("body_length expected %0d actual %0d",
						want_res.body_length, dst_data.body_length);
					fail_cnt++;
				end
				kind_seen[want_res.out_kind]++;
			end
		end
	end

	// hex digit value, or -1 for anything else
	function automatic int hex_val(input logic [7:0] c);
		if (c >= "0" && c <= "9") begin
			return int'(c - 8'h30);
		end else if (c >= "a" && c <= "f") begin
			return int'(c - 8'h61) + 10;
		end else if (c >= "A" && c <= "F") begin
			return int'(c - 8'h41) + 10;
		end
		return -1;
	endfunction

	// shadow decoder: advances its state by one accepted byte and says
	// whether that byte produces a request, and which one
	function automatic bit decode_byte(input in_req_t r, output out_req_t res);
		logic [7:0] c;
		int         hv;
		bit         hit;
		kind_t      k;
		logic [7:0] ob;
		c   = r.data_byte;
		hit = 1'b0;
		k   = KIND_DATA;
		ob  = 8'h00;
		res = '0;
		if (r.start_of_body) begin
			parse_ph    = PH_LEAD;
			size_acc    = '0;
			chunk_left  = '0;
			payload_len = '0;
			raw_len     = '0;
			size_neg    = 1'b0;
		end
		// idle or halted: byte is dropped
		if (parse_ph == PH_IDLE || parse_ph == PH_HALT) begin
			return 1'b0;
		end
		parsed_items++;
		if ({1'b0, raw_len} + 33'd1 > {1'b0, body_limit}) begin
			// this byte would take the body past the limit
			hit = 1'b1;
			k   = KIND_LONG;
		end else begin
			raw_len++;
			hv = hex_val(c);
			case (parse_ph)
				PH_LEAD: begin
					if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
						c == CH_FF) begin
						// leading white space skipped
					end else if (c == CH_CR) begin
						parse_ph = PH_CR;
					end else if (c == CH_PLUS || c == CH_MINUS) begin
						size_neg = (c == CH_MINUS);
						parse_ph = PH_DIGIT;
					end else if (hv < 0) begin
						parse_ph = PH_REST;
					end else begin
						size_acc = {size_acc[SIZE_BITS-5:0], 4'(hv)};
						parse_ph = PH_DIGIT;
					end
				end
				PH_DIGIT: begin
					if (hv >= 0) begin
						if (size_acc[SIZE_BITS-1 -: 4] != 4'h0) begin
							hit = 1'b1;
							k   = KIND_SIZE;
						end else begin
							size_acc = {size_acc[SIZE_BITS-5:0], 4'(hv)};
						end
					end else begin
						parse_ph = (c == CH_CR) ? PH_CR : PH_REST;
					end
				end
				PH_REST: begin
					if (c == CH_CR) begin
						parse_ph = PH_CR;
					end
				end
				PH_CR: begin
					if (c == CH_CR) begin
						// still waiting for the line feed
					end else if (c != CH_LF) begin
						// lone carriage return, rest of line ignored
						parse_ph = PH_REST;
					end else if (size_acc == '0) begin
						hit = 1'b1;
						k   = KIND_END;
					end else if (size_neg) begin
						hit = 1'b1;
						k   = KIND_SIZE;
					end else begin
						chunk_left = size_acc;
						parse_ph   = PH_DATA;
					end
				end
				PH_DATA: begin
					payload_len++;
					chunk_left--;
					if (chunk_left == '0) begin
						chunk_left = SIZE_BITS'(2);
						parse_ph   = PH_TRAIL;
					end
					hit = 1'b1;
					k   = KIND_DATA;
					ob  = c;
				end
				PH_TRAIL: begin
					chunk_left--;
					if (chunk_left == '0) begin
						size_acc = '0;
						size_neg = 1'b0;
						parse_ph = PH_LEAD;
					end
				end
				default: begin
					parse_ph = PH_HALT;
				end
			endcase
		end
		// every non-payload request stops the parser
		if (hit && k != KIND_DATA) begin
			ob       = 8'h00;
			parse_ph = PH_HALT;
		end
		res = '{out_byte: ob, out_kind: k, body_length: payload_len};
		return hit;
	endfunction

	// one byte request into the decoder; called at a rising edge, returns at
	// the rising edge that takes it
	task automatic push_byte(input logic [7:0] b, input logic s, input bit typed,
		input out_req_t want);
		out_req_t res;
		in_req_t  req;
		bit       hit;
		req = '{data_byte: b, start_of_body: s};
		if (src_idle_en && $urandom_range(0, 9) == 0) begin
			src_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		src_valid <= 1'b1;
		src_data  <= req;
		do @(negedge clk); while (!src_ready);
		@(posedge clk);
		sent_bytes++;
		hit = decode_byte(req, res);
		if (typed) begin
			pending_results.insert(pending_results.size(), want);
		end else if (hit) begin
			pending_results.insert(pending_results.size(), res);
		end
	endtask

	// waits until the block has gone quiet, then sets idling and the limit
	task automatic next_setting(input bit write, input logic [LEN_BITS-1:0] limit,
		input bit src_en, input bit sink_en);
		src_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		// bytes that give no request may still be in flight
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		src_idle_en  = src_en;
		sink_idle_en = sink_en;
		@(posedge clk);
		if (write) begin
			cfg_we     <= 1'b1;
			cfg_wdata  <= limit;
			body_limit  = limit;
			limits_used++;
			@(posedge clk);
			cfg_we <= 1'b0;
		end
	endtask

	task automatic put(input logic [7:0] b);
		in_req_t r;
		r = '{data_byte: b, start_of_body: 1'b0};
		body_q.insert(body_q.size(), r);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) begin
			return 8'h30 + 8'(n);
		end
		return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
	endfunction

	// size line: optional white space and sign, digits unless no_digits is set, then extension,
	// lone carriage return or doubled carriage return before CR LF
	task automatic put_size_line(input logic [SIZE_BITS-1:0] size, input bit minus,
		input bit no_digits);
		int                   ndig;
		logic [SIZE_BITS-1:0] v;
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 3)) begin
				case ($urandom_range(0, 4))
					0: put(CH_SPACE);
					1: put(CH_TAB);
					2: put(CH_LF);
					3: put(CH_VT);
					default: put(CH_FF);
				endcase
			end
		end
		if (minus) begin
			put(CH_MINUS);
		end else if ($urandom_range(0, 7) == 0) begin
			put(CH_PLUS);
		end
		if (!no_digits) begin
			ndig = 1;
			v    = size >> 4;
			while (v != '0) begin
				ndig++;
				v = v >> 4;
			end
			// a few leading zeros now and then
			if (ndig < 8) begin
				ndig += $urandom_range(0, (8 - ndig > 2) ? 2 : 8 - ndig);
			end
			for (int i = ndig - 1; i >= 0; i--) begin
				put(hex_char(4'(size >> (4 * i))));
			end
		end
		case ($urandom_range(0, 7))
			0: begin
				put(";");
				put("e");
				put("=");
				put("1");
			end
			1: begin
				put(CH_CR);
				put(8'($urandom_range(8'h67, 8'h7A)));
			end
			2: put(CH_CR);
			default: ;
		endcase
		put(CH_CR);
		put(CH_LF);
	endtask

	// builds one body: mostly well-formed, the rest errors and noise
	task automatic build_body();
		int      pick;
		int      sz;
		int      keep;
		in_req_t nb;
		body_q.delete();
		pick = $urandom_range(0, 99);
		if (pick < 66) begin
			repeat ($urandom_range(0, 3)) begin
				sz = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
				put_size_line(sz, 1'b0, 1'b0);
				repeat (sz) put(8'($urandom_range(0, 255)));
				// the two bytes after the payload are not checked by the block
				if ($urandom_range(0, 3) == 0) begin
					put(8'($urandom));
					put(8'($urandom));
				end else begin
					put(CH_CR);
					put(CH_LF);
				end
			end
			// last chunk: zero, minus zero, lone sign or no digits at all
			case ($urandom_range(0, 7))
				0: put_size_line('0, 1'b1, 1'b0);
				1: put_size_line('0, 1'($urandom_range(0, 1)), 1'b1);
				default: put_size_line('0, 1'b0, 1'b0);
			endcase
			// trailer bytes after the end are dropped
			repeat ($urandom_range(0, 2)) put(8'($urandom));
			// cut short now and then, the next start breaks in
			if ($urandom_range(0, 7) == 0) begin
				keep = $urandom_range(1, body_q.size());
				while (body_q.size() > keep) void'(body_q.pop_back());
			end
		end else if (pick < 76) begin
			// size with too many significant digits
			put(hex_char(4'($urandom_range(1, 15))));
			repeat ($urandom_range(8, 9)) put(hex_char(4'($urandom)));
		end else if (pick < 86) begin
			put_size_line(SIZE_BITS'($urandom_range(1, 4095)), 1'b1, 1'b0);
			repeat ($urandom_range(0, 3)) put(8'($urandom));
		end else if (pick < 92) begin
			// full width size, payload runs until the next start or the limit
			put_size_line({4'($urandom_range(1, 15)), 28'($urandom)}, 1'b0, 1'b0);
			repeat ($urandom_range(5, 30)) put(8'($urandom));
		end else begin
			repeat ($urandom_range(4, 30)) begin
				nb = '{data_byte: 8'($urandom),
					start_of_body: ($urandom_range(0, 15) == 0)};
				body_q.insert(body_q.size(), nb);
			end
		end
		if (pick < 92 || $urandom_range(0, 1) == 1) begin
			body_q[0].start_of_body = 1'b1;
		end
	endtask

	initial begin
		int unsigned         goal;
		int unsigned         n;
		logic [LEN_BITS-1:0] lim;
		bit                  wr;
		bit                  se;
		bit                  ke;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed requests straight after reset, limit at its reset value
		foreach (directed_rows[i]) begin
			push_byte(directed_rows[i].b, directed_rows[i].s, directed_rows[i].typed,
				directed_rows[i].want);
		end

		// random bodies under a range of limits, both extremes included;
		// the last setting runs with no idling on either side
		for (int p = 0; p < 7; p++) begin
			case (p)
				0: begin
					wr = 1'b0; lim = MAX_LEN_RESET; se = 1'b1; ke = 1'b1; n = 180;
				end
				1: begin
					wr = 1'b1; lim = '0; se = 1'b1; ke = 1'b1; n = 50;
				end
				2: begin
					wr = 1'b1; lim = 32'd1; se = 1'b1; ke = 1'b1; n = 50;
				end
				3: begin
					wr = 1'b1; lim = $urandom_range(8, 60); se = 1'b1; ke = 1'b0; n = 220;
				end
				4: begin
					wr = 1'b1; lim = $urandom_range(100, 600); se = 1'b0; ke = 1'b1; n = 220;
				end
				5: begin
					wr = 1'b1; lim = '1; se = 1'b1; ke = 1'b1; n = 220;
				end
				default: begin
					wr = 1'b1; lim = 32'($urandom) | 32'h8000_0000; se = 1'b0; ke = 1'b0;
					n = 220;
				end
			endcase
			next_setting(wr, lim, se, ke);
			goal = sent_bytes + n;
			while (sent_bytes < goal) begin
				build_body();
				foreach (body_q[i]) begin
					push_byte(body_q[i].data_byte, body_q[i].start_of_body, 1'b0, '0);
				end
				bodies_sent++;
			end
		end

		// drain the last requests and let the block settle
		next_setting(1'b0, '0, 1'b0, 1'b0);

		$display("covered %0d bodies, %0d bytes sent of which %0d parsed, %0d limit writes",
			bodies_sent, sent_bytes, parsed_items, limits_used);
		$display("requests checked: %0d payload, %0d body end, %0d size error, %0d too long",
			kind_seen[KIND_DATA], kind_seen[KIND_END], kind_seen[KIND_SIZE],
			kind_seen[KIND_LONG]);
		if (fail_cnt == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
